[src/apr_pkg.sv]
// ----------------------------------------------------------------------------
// apr_pkg: shared definitions for the aging page replacement table
// Field widths, command and status codes, default sizes and the control
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package apr_pkg;

	// Default sizes handed to the top level parameters.
	localparam int TABLE_ENTRIES_DEF = 256;
	localparam int HISTORY_BITS_DEF  = 8;

	// Fixed field widths of the request and response beats.
	localparam int CMD_W    = 3;
	localparam int SPACE_W  = 16;
	localparam int PAGE_W   = 27;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 8;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_REGISTER   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UNREGISTER = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ACCESS     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TICK       = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SWAP_OUT   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SWAP_IN    = 3'd5;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_MAPPED  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_VICTIM   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_SWAPPED = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the request and restart the scan
		logic clear;   // write the entry at the counter as unused
		logic rd_en;   // read the entry at the counter
		logic finish;  // apply the final update and load the result
	} apr_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cnt_last;  // counter points at the last entry
		logic no_scan;   // captured command is not a known code
	} apr_sts_t;

endpackage

[src/apr_if.sv]
// ----------------------------------------------------------------------------
// apr_if: request and response channels of the page replacement table
// Each channel carries valid, ready and its payload fields.
// ----------------------------------------------------------------------------
interface apr_req_if import apr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [SPACE_W-1:0] address_space;
	logic [PAGE_W-1:0]  virtual_page;

	modport source (output valid, command, address_space, virtual_page, input ready);
	modport sink (input valid, command, address_space, virtual_page, output ready);
endinterface

interface apr_rsp_if import apr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;
	logic [SPACE_W-1:0]  victim_space;
	logic [PAGE_W-1:0]   victim_page;
	logic                was_swapped;

	modport source (output valid, status, slot, victim_space, victim_page, was_swapped,
		input ready);
	modport sink (input valid, status, slot, victim_space, victim_page, was_swapped,
		output ready);
endinterface

[src/apr_ctrl.sv]
// ----------------------------------------------------------------------------
// apr_ctrl: sequencer of the page replacement table
// Runs the clearing pass after reset, then for each known command a full
// table scan, a drain state and a finishing update, and owns both handshakes.
// ----------------------------------------------------------------------------
module apr_ctrl import apr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output apr_ctl_t ctl,
	input  apr_sts_t sts
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_valid_q;
	logic       can_finish;

	// The result register is free when empty or being taken in this cycle.
	assign can_finish = !rsp_valid_q || rsp_ready;
	assign req_ready  = (state_q == S_IDLE);
	assign rsp_valid  = rsp_valid_q;

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		ctl        = '0;
		unique case (state_q)
			S_CLEAR: begin
				ctl.clear = 1'b1;
				if (sts.cnt_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.no_scan) begin
					state_d = S_FINISH;
				end else begin
					ctl.rd_en = 1'b1;
					if (sts.cnt_last) begin
						state_d = S_DRAIN;
					end
				end
			end
			S_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (can_finish) begin
					ctl.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

[src/apr_datapath.sv]
// ----------------------------------------------------------------------------
// apr_datapath: entry memory, scan logic and result register
// Holds the table in a single-port-write, single-port-read memory, walks it
// one entry per cycle and applies the final update of each command.
// ----------------------------------------------------------------------------
module apr_datapath import apr_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int HISTORY_BITS  = HISTORY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  apr_ctl_t            ctl,
	output apr_sts_t            sts,
	input  logic [CMD_W-1:0]    command,
	input  logic [SPACE_W-1:0]  address_space,
	input  logic [PAGE_W-1:0]   virtual_page,
	output logic [STATUS_W-1:0] status,
	output logic [SLOT_W-1:0]   slot,
	output logic [SPACE_W-1:0]  victim_space,
	output logic [PAGE_W-1:0]   victim_page,
	output logic                was_swapped
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	typedef struct packed {
		logic                    used;
		logic [SPACE_W-1:0]      space;
		logic [PAGE_W-1:0]       page;
		logic [HISTORY_BITS-1:0] hist;
		logic                    refd;
		logic                    res;
		logic                    swp;
	} entry_t;

	entry_t mem [TABLE_ENTRIES];

	// Captured request.
	logic [CMD_W-1:0]   cmd_q;
	logic [SPACE_W-1:0] space_q;
	logic [PAGE_W-1:0]  page_q;

	// Scan counter and read pipeline.
	logic [IDX_W-1:0] cnt_q;
	logic             valid_s1;
	logic [IDX_W-1:0] raddr_s1;
	entry_t           rdata_s1;

	// Scan trackers: the hit (first match or best victim) and the first free slot.
	logic             hit_found_q;
	logic [IDX_W-1:0] hit_slot_q;
	entry_t           hit_word_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_slot_q;

	// Result register.
	logic [STATUS_W-1:0] status_q;
	logic [IDX_W-1:0]    slot_q;
	logic [SPACE_W-1:0]  vspace_q;
	logic [PAGE_W-1:0]   vpage_q;
	logic                wasswp_q;

	// Per-entry decisions and write port.
	logic                      is_match;
	logic                      is_free;
	logic                      is_better;
	logic                      tick_we;
	entry_t                    tick_word;
	logic                      fin_we;
	logic [IDX_W-1:0]          fin_addr;
	entry_t                    fin_word;
	logic [STATUS_W-1:0]       fin_status;
	logic [IDX_W-1:0]          fin_slot;
	logic [SPACE_W-1:0]        fin_vspace;
	logic [PAGE_W-1:0]         fin_vpage;
	logic                      fin_wasswp;
	logic                      we;
	logic [IDX_W-1:0]          waddr;
	entry_t                    wdata;
	logic [SLOT_W+IDX_W-1:0]   slot_ext;

	assign sts.cnt_last = (cnt_q == LAST_IDX);
	assign sts.no_scan  = (cmd_q > CMD_SWAP_IN);

	// Classification of the entry leaving the read register.
	assign is_match  = rdata_s1.used && (rdata_s1.space == space_q) &&
		(rdata_s1.page == page_q);
	assign is_free   = !rdata_s1.used;
	assign is_better = rdata_s1.used && rdata_s1.res &&
		(!hit_found_q || (rdata_s1.hist < hit_word_q.hist));

	// An age tick shifts the referenced bit into the top of the history.
	assign tick_we = valid_s1 && (cmd_q == CMD_TICK) && rdata_s1.used && rdata_s1.res;
	always_comb begin
		tick_word      = rdata_s1;
		tick_word.hist = {rdata_s1.refd, rdata_s1.hist[HISTORY_BITS-1:1]};
		tick_word.refd = 1'b0;
	end

	// Final update and result of each command.
	always_comb begin
		fin_we     = 1'b0;
		fin_addr   = hit_slot_q;
		fin_word   = hit_word_q;
		fin_status = ST_OK;
		fin_slot   = '0;
		fin_vspace = '0;
		fin_vpage  = '0;
		fin_wasswp = 1'b0;
		unique case (cmd_q)
			CMD_REGISTER: begin
				if (hit_found_q) begin
					fin_status = ST_DUPLICATE;
					fin_slot   = hit_slot_q;
				end else if (free_found_q) begin
					fin_we     = 1'b1;
					fin_addr   = free_slot_q;
					fin_word   = '{used: 1'b1, space: space_q, page: page_q,
						hist: '0, refd: 1'b0, res: 1'b1, swp: 1'b0};
					fin_slot   = free_slot_q;
				end else begin
					fin_status = ST_FULL;
				end
			end
			CMD_UNREGISTER: begin
				if (hit_found_q) begin
					fin_we     = 1'b1;
					fin_word   = '0;
					fin_slot   = hit_slot_q;
					fin_wasswp = hit_word_q.swp;
				end else begin
					fin_status = ST_NOT_MAPPED;
				end
			end
			CMD_ACCESS: begin
				if (hit_found_q) begin
					fin_we        = 1'b1;
					fin_word.refd = 1'b1;
					fin_slot      = hit_slot_q;
				end else begin
					fin_status = ST_NOT_MAPPED;
				end
			end
			CMD_SWAP_OUT: begin
				if (hit_found_q) begin
					fin_we        = 1'b1;
					fin_word.res  = 1'b0;
					fin_word.swp  = 1'b1;
					fin_word.hist = '0;
					fin_slot      = hit_slot_q;
					fin_vspace    = hit_word_q.space;
					fin_vpage     = hit_word_q.page;
				end else begin
					fin_status = ST_NO_VICTIM;
				end
			end
			CMD_SWAP_IN: begin
				if (!hit_found_q) begin
					fin_status = ST_NOT_MAPPED;
				end else if (!hit_word_q.swp) begin
					fin_status = ST_NOT_SWAPPED;
					fin_slot   = hit_slot_q;
				end else begin
					fin_we       = 1'b1;
					fin_word.swp = 1'b0;
					fin_word.res = 1'b1;
					fin_slot     = hit_slot_q;
				end
			end
			default: begin
				// Age tick and unknown codes report ok with zero fields.
				fin_status = ST_OK;
			end
		endcase
	end

	// Single write port: clearing pass, tick write-back, final update.
	always_comb begin
		we    = 1'b0;
		waddr = cnt_q;
		wdata = '0;
		priority if (ctl.clear) begin
			we = 1'b1;
		end else if (tick_we) begin
			we    = 1'b1;
			waddr = raddr_s1;
			wdata = tick_word;
		end else if (ctl.finish && fin_we) begin
			we    = 1'b1;
			waddr = fin_addr;
			wdata = fin_word;
		end
	end

	// Entry memory with registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata_s1 <= mem[cnt_q];
			raddr_s1 <= cnt_q;
		end
	end

	// Counter, read valid and scan flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			valid_s1     <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			cmd_q        <= CMD_TICK;
		end else begin
			valid_s1 <= ctl.rd_en;
			if (ctl.load) begin
				cnt_q        <= '0;
				hit_found_q  <= 1'b0;
				free_found_q <= 1'b0;
				cmd_q        <= command;
			end else begin
				if (ctl.clear || ctl.rd_en) begin
					cnt_q <= sts.cnt_last ? '0 : cnt_q + 1'b1;
				end
				if (valid_s1) begin
					if (cmd_q == CMD_SWAP_OUT) begin
						if (is_better) begin
							hit_found_q <= 1'b1;
						end
					end else if (is_match) begin
						hit_found_q <= 1'b1;
					end
					if (is_free) begin
						free_found_q <= 1'b1;
					end
				end
			end
		end
	end

	// Request capture and tracker payload.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			space_q <= address_space;
			page_q  <= virtual_page;
		end
		if (valid_s1) begin
			if (cmd_q == CMD_SWAP_OUT) begin
				if (is_better) begin
					hit_slot_q <= raddr_s1;
					hit_word_q <= rdata_s1;
				end
			end else if (is_match && !hit_found_q) begin
				hit_slot_q <= raddr_s1;
				hit_word_q <= rdata_s1;
			end
			if (is_free && !free_found_q) begin
				free_slot_q <= raddr_s1;
			end
		end
	end

	// Result register, loaded as the command finishes.
	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			status_q <= fin_status;
			slot_q   <= fin_slot;
			vspace_q <= fin_vspace;
			vpage_q  <= fin_vpage;
			wasswp_q <= fin_wasswp;
		end
	end

	// The slot field carries the low bits of the index.
	assign slot_ext     = {{SLOT_W{1'b0}}, slot_q};
	assign slot         = slot_ext[SLOT_W-1:0];
	assign status       = status_q;
	assign victim_space = vspace_q;
	assign victim_page  = vpage_q;
	assign was_swapped  = wasswp_q;

endmodule

[src/aging_page_replacement_table_unit.sv]
// ----------------------------------------------------------------------------
// aging_page_replacement_table_unit: aging page replacement table
// Tracks pages by address space and virtual page with an aging history.
//
// Usage: a request beat on req carries a command, an address space and a
// virtual page; every request gives exactly one response beat on rsp with a
// status, a slot, the swap-out victim key and the swapped flag.
// Each request walks the whole entry memory, one entry per cycle through
// its single read port, and a new request is taken the cycle after the
// response is loaded. Unknown command codes skip the walk. The rate is set
// by this walk. After reset a clearing pass marks all TABLE_ENTRIES
// entries unused, one per cycle; req.ready stays low throughout the pass.
// A response waits in an output register while rsp.ready is low; the next
// request may be accepted and walked meanwhile, and it holds at its final
// step until the register is free.
// ----------------------------------------------------------------------------
module aging_page_replacement_table_unit import apr_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int HISTORY_BITS  = HISTORY_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	apr_req_if.sink          req,
	apr_rsp_if.source        rsp
);

	apr_ctl_t ctl;
	apr_sts_t sts;

	// Sequencer and handshakes.
	apr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.ctl       (ctl),
		.sts       (sts)
	);

	// Entry memory, scan and result.
	apr_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.HISTORY_BITS  (HISTORY_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.command       (req.command),
		.address_space (req.address_space),
		.virtual_page  (req.virtual_page),
		.status        (rsp.status),
		.slot          (rsp.slot),
		.victim_space  (rsp.victim_space),
		.victim_page   (rsp.victim_page),
		.was_swapped   (rsp.was_swapped)
	);

endmodule

[tb/aging_page_replacement_table_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_page_replacement_table_unit_tb: self-checking bench for the aging table
// Command beats go in with bursty timing. A behavioural copy of the page table
// works out every response beat as each command is accepted. Each response is
// compared field by field while the response side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module aging_page_replacement_table_unit_tb;
	import apr_pkg::*;

	localparam int ENTRIES      = TABLE_ENTRIES_DEF;
	localparam int HIST_W       = HISTORY_BITS_DEF;
	localparam int POOL_SIZE    = 20;
	localparam int RANDOM_BEATS = 960;
	localparam int HOLD_CYCLES  = 1500;
	localparam int DRAIN_CYCLES = ENTRIES + 40;

	// Command codes the block ignores.
	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [SPACE_W-1:0]  victim_space;
		logic [PAGE_W-1:0]   victim_page;
		logic                was_swapped;
	} page_result_t;

	logic clk = 1'b0;
	logic arst_n;

	apr_req_if req ();
	apr_rsp_if rsp ();

	aging_page_replacement_table_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// Shadow copy of the page table.
	bit                 slot_used     [ENTRIES];
	logic [SPACE_W-1:0] slot_space    [ENTRIES];
	logic [PAGE_W-1:0]  slot_page     [ENTRIES];
	logic [HIST_W-1:0]  slot_history  [ENTRIES];
	bit                 slot_ref      [ENTRIES];
	bit                 slot_resident [ENTRIES];
	bit                 slot_swapped  [ENTRIES];

	page_result_t       pending_results[$];
	int                 mismatches    = 0;
	int                 burst_left    = 0;
	int                 hold_requests = 0;
	logic [SPACE_W-1:0] pool_space [POOL_SIZE];
	logic [PAGE_W-1:0]  pool_page  [POOL_SIZE];

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Returns the slot holding this key, or -1 when the key is not tracked.
	function automatic int find_slot(input logic [SPACE_W-1:0] space,
			input logic [PAGE_W-1:0] page);
		for (int i = 0; i < ENTRIES; i++) begin
			if (slot_used[i] && slot_space[i] == space && slot_page[i] == page)
				return i;
		end
		return -1;
	endfunction

	function automatic bit table_is_full();
		foreach (slot_used[i]) begin
			if (!slot_used[i])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Applies one command to the shadow table and returns the response it causes.
	function automatic page_result_t apply_command(input logic [CMD_W-1:0] command,
			input logic [SPACE_W-1:0] space, input logic [PAGE_W-1:0] page);
		page_result_t res;
		int hit;
		bit found;
		int best;
		res = '0;
		res.status = ST_OK;
		hit = find_slot(space, page);
		found = 1'b0;
		best = 0;
		unique case (command)
			CMD_REGISTER: begin
				if (hit >= 0) begin
					res.status = ST_DUPLICATE;
					res.slot = SLOT_W'(hit);
				end else begin
					// First free slot wins; nothing free means the table is full.
					res.status = ST_FULL;
					for (int i = 0; i < ENTRIES; i++) begin
						if (!slot_used[i] && !found) begin
							found = 1'b1;
							slot_used[i] = 1'b1;
							slot_space[i] = space;
							slot_page[i] = page;
							slot_history[i] = '0;
							slot_ref[i] = 1'b0;
							slot_resident[i] = 1'b1;
							slot_swapped[i] = 1'b0;
							res.status = ST_OK;
							res.slot = SLOT_W'(i);
						end
					end
				end
			end
			CMD_UNREGISTER: begin
				if (hit < 0) begin
					res.status = ST_NOT_MAPPED;
				end else begin
					res.slot = SLOT_W'(hit);
					res.was_swapped = slot_swapped[hit];
					slot_used[hit] = 1'b0;
					slot_space[hit] = '0;
					slot_page[hit] = '0;
					slot_history[hit] = '0;
					slot_ref[hit] = 1'b0;
					slot_resident[hit] = 1'b0;
					slot_swapped[hit] = 1'b0;
				end
			end
			CMD_ACCESS: begin
				if (hit < 0) begin
					res.status = ST_NOT_MAPPED;
				end else begin
					res.slot = SLOT_W'(hit);
					slot_ref[hit] = 1'b1;
				end
			end
			CMD_TICK: begin
				// Swapped-out entries keep their history and referenced bit.
				for (int i = 0; i < ENTRIES; i++) begin
					if (slot_used[i] && slot_resident[i]) begin
						slot_history[i] = {slot_ref[i], slot_history[i][HIST_W-1:1]};
						slot_ref[i] = 1'b0;
					end
				end
			end
			CMD_SWAP_OUT: begin
				// Least history among resident entries, lowest slot on a tie.
				for (int i = 0; i < ENTRIES; i++) begin
					if (slot_used[i] && slot_resident[i]) begin
						if (!found || slot_history[i] < slot_history[best]) begin
							found = 1'b1;
							best = i;
						end
					end
				end
				if (!found) begin
					res.status = ST_NO_VICTIM;
				end else begin
					res.slot = SLOT_W'(best);
					res.victim_space = slot_space[best];
					res.victim_page = slot_page[best];
					slot_resident[best] = 1'b0;
					slot_swapped[best] = 1'b1;
					slot_history[best] = '0;
				end
			end
			CMD_SWAP_IN: begin
				if (hit < 0) begin
					res.status = ST_NOT_MAPPED;
				end else if (!slot_swapped[hit]) begin
					res.status = ST_NOT_SWAPPED;
					res.slot = SLOT_W'(hit);
				end else begin
					res.slot = SLOT_W'(hit);
					slot_swapped[hit] = 1'b0;
					slot_resident[hit] = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// Offers one command beat, idling between bursts, and records its response.
	task automatic send_command(input logic [CMD_W-1:0] command,
			input logic [SPACE_W-1:0] space, input logic [PAGE_W-1:0] page);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 9) == 0)
				gap = $urandom_range(1, 300);
			else if ($urandom_range(0, 1) == 0)
				gap = 0;
			else
				gap = $urandom_range(1, 4);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.valid <= 1'b1;
		req.command <= command;
		req.address_space <= space;
		req.virtual_page <= page;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		pending_results.push_back(apply_command(command, space, page));
	endtask

	// Stops offering beats until every outstanding response has come back.
	task automatic wait_for_results();
		req.valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() > 0)
			@(posedge clk);
	endtask

	// One command drawn mostly from the key pool, with a few stray keys.
	task automatic send_random_beat();
		logic [CMD_W-1:0] command;
		logic [SPACE_W-1:0] space;
		logic [PAGE_W-1:0] page;
		int roll;
		int pick;
		roll = $urandom_range(0, 99);
		if (roll < 20)
			command = CMD_REGISTER;
		else if (roll < 32)
			command = CMD_UNREGISTER;
		else if (roll < 56)
			command = CMD_ACCESS;
		else if (roll < 74)
			command = CMD_TICK;
		else if (roll < 86)
			command = CMD_SWAP_OUT;
		else if (roll < 98)
			command = CMD_SWAP_IN;
		else
			command = ($urandom_range(0, 1) == 0) ? CMD_UNUSED_LO : CMD_UNUSED_HI;
		pick = $urandom_range(0, POOL_SIZE - 1);
		if ($urandom_range(0, 9) == 0) begin
			space = SPACE_W'($urandom);
			page = PAGE_W'($urandom);
		end else begin
			space = pool_space[pick];
			page = pool_page[pick];
		end
		send_command(command, space, page);
	endtask

	// Field extremes, every command and the corner cases.
	task automatic test_directed_cases();
		send_command(CMD_SWAP_OUT, '0, '0);
		send_command(CMD_TICK, '1, '1);
		send_command(CMD_UNREGISTER, '1, '1);
		send_command(CMD_ACCESS, '1, '1);
		send_command(CMD_SWAP_IN, '1, '1);
		send_command(CMD_REGISTER, '0, '0);
		send_command(CMD_REGISTER, '1, '1);
		send_command(CMD_REGISTER, '0, '0);
		send_command(CMD_SWAP_IN, '0, '0);
		send_command(CMD_ACCESS, '1, '1);
		send_command(CMD_TICK, '0, '0);
		send_command(CMD_SWAP_OUT, '0, '0);
		// The referenced bit of a swapped-out page waits until it is back.
		send_command(CMD_ACCESS, '0, '0);
		send_command(CMD_TICK, '0, '0);
		send_command(CMD_SWAP_IN, '0, '0);
		send_command(CMD_TICK, '0, '0);
		send_command(CMD_SWAP_OUT, '0, '0);
		send_command(CMD_UNREGISTER, '1, '1);
		send_command(CMD_UNREGISTER, '0, '0);
		send_command(CMD_UNUSED_LO, '1, '1);
		send_command(CMD_UNUSED_HI, '0, '0);
		send_command(CMD_REGISTER, 16'hAAAA, 27'h5555555);
		send_command(CMD_REGISTER, 16'h5555, 27'h2AAAAAA);
		send_command(CMD_UNREGISTER, 16'hAAAA, 27'h5555555);
		send_command(CMD_UNREGISTER, 16'h5555, 27'h2AAAAAA);
	endtask

	// A page referenced on every tick still gets evicted when it is the only one.
	task automatic test_saturated_victim();
		logic [SPACE_W-1:0] space;
		logic [PAGE_W-1:0] page;
		space = SPACE_W'($urandom);
		page = PAGE_W'($urandom);
		send_command(CMD_REGISTER, space, page);
		repeat (HIST_W) begin
			send_command(CMD_ACCESS, space, page);
			send_command(CMD_TICK, SPACE_W'($urandom), PAGE_W'($urandom));
		end
		send_command(CMD_SWAP_OUT, '0, '0);
		send_command(CMD_UNREGISTER, space, page);
	endtask

	// Mixed traffic over a small pool of keys so that most commands hit.
	task automatic test_random_traffic();
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_space[i] = SPACE_W'($urandom);
			pool_page[i] = PAGE_W'($urandom);
		end
		pool_space[0] = '0;
		pool_page[0] = '0;
		pool_space[1] = '1;
		pool_page[1] = '1;
		repeat (RANDOM_BEATS)
			send_random_beat();
		wait_for_results();
	endtask

	// The response side holds off while commands keep coming, so the block fills.
	task automatic test_output_backpressure();
		hold_requests <= hold_requests + 1;
		burst_left = 20;
		repeat (12)
			send_random_beat();
		wait_for_results();
	endtask

	// Fill every slot, hit the full table, then empty it from the top down.
	task automatic test_table_full();
		while (!table_is_full())
			send_command(CMD_REGISTER, SPACE_W'($urandom), PAGE_W'($urandom));
		send_command(CMD_REGISTER, SPACE_W'($urandom), PAGE_W'($urandom));
		send_command(CMD_REGISTER, slot_space[ENTRIES-1], slot_page[ENTRIES-1]);
		send_command(CMD_ACCESS, slot_space[ENTRIES-2], slot_page[ENTRIES-2]);
		send_command(CMD_TICK, '0, '0);
		repeat (3)
			send_command(CMD_SWAP_OUT, '0, '0);
		send_command(CMD_SWAP_IN, slot_space[0], slot_page[0]);
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (slot_used[i])
				send_command(CMD_UNREGISTER, slot_space[i], slot_page[i]);
		end
		send_command(CMD_SWAP_OUT, '0, '0);
	endtask

	// Response side: random stalls in windows of changing density, plus long holds.
	initial begin : response_side
		int stall_left;
		int hold_left;
		int holds_seen;
		int window_left;
		int stall_pct;
		stall_left = 0;
		hold_left = 0;
		holds_seen = 0;
		window_left = 0;
		stall_pct = 0;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_seen != hold_requests) begin
				holds_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (window_left == 0) begin
				window_left = $urandom_range(200, 2000);
				stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 60);
			end
			window_left--;
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				if ($urandom_range(0, 15) == 0)
					stall_left = $urandom_range(20, 300);
				else
					stall_left = $urandom_range(0, 12);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Each response beat is matched against the oldest outstanding prediction.
	always @(posedge clk) begin : response_check
		page_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected response beat: status %0d slot %0d",
					rsp.status, rsp.slot);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(want.status), 32'(rsp.status));
				check_field("slot", 32'(want.slot), 32'(rsp.slot));
				check_field("victim_space", 32'(want.victim_space),
					32'(rsp.victim_space));
				check_field("victim_page", 32'(want.victim_page),
					32'(rsp.victim_page));
				check_field("was_swapped", 32'(want.was_swapped),
					32'(rsp.was_swapped));
			end
		end
	end

	// Test sequence.
	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.command = CMD_REGISTER;
		req.address_space = '0;
		req.virtual_page = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_saturated_victim();
		test_random_traffic();
		test_output_backpressure();
		test_table_full();
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[aging_page_replacement_table_unit] OK");
		else
			$display("[aging_page_replacement_table_unit] ERROR");
		$finish;
	end

	// Watchdog, well beyond the slowest correct run.
	initial begin
		#(64'd60_000_000);
		$display("[aging_page_replacement_table_unit] ERROR");
		$finish;
	end

endmodule
